// ===== sv/bmc_pkg.sv =====
// ----------------------------------------------------------------------------
// bmc_pkg
// Shared constants, operation and status codes, and control structs of the
// blocking message channel.
// ----------------------------------------------------------------------------
package bmc_pkg;

	// default sizes
	localparam int BUF_DEPTH_DEF  = 16;
	localparam int WAIT_DEPTH_DEF = 8;
	localparam int VALUE_W_DEF    = 32;
	localparam int ID_W_DEF       = 8;

	// fixed field widths
	localparam int CAP_W  = 5;
	localparam int FUNC_W = 2;
	localparam int STAT_W = 2;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_SEND  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_RECV  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_CLOSE = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] ST_BLOCKED = 2'd1;
	localparam logic [STAT_W-1:0] ST_CLOSED  = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

	// waiter queue control and status
	typedef struct packed {
		logic push;
		logic pop;
	} wq_ctrl_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic single;
	} wq_stat_t;

endpackage

// ===== sv/bmc_req_if.sv =====
// ----------------------------------------------------------------------------
// bmc_req_if
// Request channel: one operation beat from a thread.
// ----------------------------------------------------------------------------
interface bmc_req_if #(
	parameter int VALUE_W = bmc_pkg::VALUE_W_DEF,
	parameter int ID_W    = bmc_pkg::ID_W_DEF
);
	import bmc_pkg::*;

	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [ID_W-1:0]   thread_id;
	logic [VALUE_W-1:0] data_in;

	modport source (output valid, func, thread_id, data_in, input ready);
	modport sink   (input valid, func, thread_id, data_in, output ready);
endinterface

// ===== sv/bmc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bmc_rsp_if
// Result channel: one result beat, possibly resuming a waiting thread.
// ----------------------------------------------------------------------------
interface bmc_rsp_if #(
	parameter int VALUE_W = bmc_pkg::VALUE_W_DEF,
	parameter int ID_W    = bmc_pkg::ID_W_DEF
);
	import bmc_pkg::*;

	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic [VALUE_W-1:0] data_out;
	logic               wake_valid;
	logic [ID_W-1:0]    wake_id;
	logic [VALUE_W-1:0] wake_data;
	logic               last;

	modport source (output valid, status, data_out, wake_valid, wake_id, wake_data, last,
		input ready);
	modport sink   (input valid, status, data_out, wake_valid, wake_id, wake_data, last,
		output ready);
endinterface

// ===== sv/bmc_wait_q.sv =====
// ----------------------------------------------------------------------------
// bmc_wait_q
// Ring queue of blocked threads with a registered read of the head entry.
// The head data is valid from the cycle after the head pointer last moved.
// ----------------------------------------------------------------------------
module bmc_wait_q #(
	parameter int DEPTH  = bmc_pkg::WAIT_DEPTH_DEF,
	parameter int DATA_W = bmc_pkg::ID_W_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bmc_pkg::wq_ctrl_t ctrl,
	input  logic [DATA_W-1:0] push_data,
	output logic [DATA_W-1:0] head_data,
	output bmc_pkg::wq_stat_t stat
);
	import bmc_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = IDX_W + 1;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] rd_q;
	logic [SUM_W-1:0]  tail_sum;
	logic [IDX_W-1:0]  tail;
	logic [IDX_W-1:0]  head_nxt;

	// tail index, sum stays below twice the depth
	assign tail_sum = SUM_W'(head_q) + SUM_W'(cnt_q);
	assign tail     = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
		: IDX_W'(tail_sum);
	assign head_nxt = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;

	// entry storage and registered head read
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[tail] <= push_data;
		end
		rd_q <= mem[head_q];
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (ctrl.pop) begin
				head_q <= head_nxt;
			end
			case ({ctrl.push, ctrl.pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head_data   = rd_q;
	assign stat.empty  = (cnt_q == '0);
	assign stat.full   = (cnt_q == CNT_W'(DEPTH));
	assign stat.single = (cnt_q == CNT_W'(1));

endmodule

// ===== sv/blocking_message_channel.sv =====
// ----------------------------------------------------------------------------
// blocking_message_channel
// Message channel between threads: value buffer plus sender and receiver
// waiter queues, driven by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   req carries send, receive and close beats; rsp returns result beats, and
//   every request produces results ending with last set (unused code 3
//   produces none). cfg_we/cfg_wdata set the buffer capacity; the user must
//   write them only while idle, as the block itself does not enforce it.
//   Send and receive pass an accept cycle, where the registered head reads
//   of the buffer and queues settle, and a decision cycle that loads the
//   result register and updates the stores. Close with no waiter answers
//   from the decision cycle; with waiters it is followed by a wake state per
//   waiter, with a gap state between wakes, since the registered head read
//   of a queue must settle after every pop before the next wake.
//   req.ready is high only while the sequencer is idle; a finished result
//   may still wait in the output register while the next request is taken.
//   When rsp is stalled the decision cycle holds until the output register
//   frees up, so nothing is lost.
//   Reset empties the buffer and both queues, opens the channel and clears
//   capacity to zero (unbuffered); store contents are not cleared.
// ----------------------------------------------------------------------------
module blocking_message_channel #(
	parameter int BUF_DEPTH  = bmc_pkg::BUF_DEPTH_DEF,
	parameter int WAIT_DEPTH = bmc_pkg::WAIT_DEPTH_DEF,
	parameter int VALUE_W    = bmc_pkg::VALUE_W_DEF,
	parameter int ID_W       = bmc_pkg::ID_W_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	bmc_req_if.sink                  req,
	bmc_rsp_if.source                rsp,
	input  logic                     cfg_we,
	input  logic [bmc_pkg::CAP_W-1:0] cfg_wdata
);
	import bmc_pkg::*;

	localparam int BIDX_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int BCNT_W = $clog2(BUF_DEPTH + 1);
	localparam int BSUM_W = BIDX_W + 1;
	localparam int CMP_W  = (CAP_W > BCNT_W) ? CAP_W : BCNT_W;
	localparam int SQ_W   = ID_W + VALUE_W;

	// sequencer states
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EXEC  = 2'd1;
	localparam logic [1:0] S_CLOSE = 2'd2;
	localparam logic [1:0] S_GAP   = 2'd3;

	logic [1:0]         state_q, state_nxt;
	logic [FUNC_W-1:0]  func_q;
	logic [ID_W-1:0]    tid_q;
	logic [VALUE_W-1:0] din_q;
	logic [CAP_W-1:0]   cap_q;
	logic               closed_q;

	// buffer
	logic [VALUE_W-1:0] buf_mem [BUF_DEPTH];
	logic [BIDX_W-1:0]  buf_head_q;
	logic [BCNT_W-1:0]  buf_cnt_q;
	logic [VALUE_W-1:0] buf_rd_q;
	logic [BSUM_W-1:0]  buf_sum;
	logic [BIDX_W-1:0]  buf_tail;
	logic [BIDX_W-1:0]  buf_head_nxt;
	logic               buf_we;
	logic [VALUE_W-1:0] buf_wdata;
	logic               buf_pop;
	logic               buf_inc;
	logic               buf_dec;

	// capacity compare
	logic [CMP_W-1:0]   cap_eff;
	logic               buf_has_room;

	// waiter queues
	wq_ctrl_t           snd_ctrl, rcv_ctrl;
	wq_stat_t           snd_stat, rcv_stat;
	logic [SQ_W-1:0]    snd_head;
	logic [ID_W-1:0]    rcv_head;
	logic [ID_W-1:0]    snd_head_id;
	logic [VALUE_W-1:0] snd_head_val;

	// result register
	logic               rsp_valid_q;
	logic [STAT_W-1:0]  status_q;
	logic [VALUE_W-1:0] dout_q;
	logic               wv_q;
	logic [ID_W-1:0]    wid_q;
	logic [VALUE_W-1:0] wdata_q;
	logic               last_q;

	logic               out_free;
	logic               load;
	logic               closed_set;
	logic [STAT_W-1:0]  r_status;
	logic [VALUE_W-1:0] r_dout;
	logic               r_wv;
	logic [ID_W-1:0]    r_wid;
	logic [VALUE_W-1:0] r_wdata;
	logic               r_last;

	bmc_wait_q #(.DEPTH(WAIT_DEPTH), .DATA_W(SQ_W)) u_snd_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (snd_ctrl),
		.push_data ({tid_q, din_q}),
		.head_data (snd_head),
		.stat      (snd_stat)
	);

	bmc_wait_q #(.DEPTH(WAIT_DEPTH), .DATA_W(ID_W)) u_rcv_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (rcv_ctrl),
		.push_data (tid_q),
		.head_data (rcv_head),
		.stat      (rcv_stat)
	);

	assign snd_head_val = snd_head[VALUE_W-1:0];
	assign snd_head_id  = snd_head[SQ_W-1:VALUE_W];

	// buffer ring indexes
	assign buf_sum      = BSUM_W'(buf_head_q) + BSUM_W'(buf_cnt_q);
	assign buf_tail     = (buf_sum >= BSUM_W'(BUF_DEPTH))
		? BIDX_W'(buf_sum - BSUM_W'(BUF_DEPTH)) : BIDX_W'(buf_sum);
	assign buf_head_nxt = (buf_head_q == BIDX_W'(BUF_DEPTH - 1)) ? '0 : buf_head_q + 1'b1;

	// capacity clipped to the buffer size
	assign cap_eff      = (CMP_W'(cap_q) > CMP_W'(BUF_DEPTH)) ? CMP_W'(BUF_DEPTH)
		: CMP_W'(cap_q);
	assign buf_has_room = (cap_eff != '0) && (CMP_W'(buf_cnt_q) < cap_eff);

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);

	// decision logic
	always_comb begin
		state_nxt  = state_q;
		load       = 1'b0;
		closed_set = 1'b0;
		snd_ctrl   = '0;
		rcv_ctrl   = '0;
		buf_we     = 1'b0;
		buf_wdata  = din_q;
		buf_pop    = 1'b0;
		buf_inc    = 1'b0;
		buf_dec    = 1'b0;
		r_status   = ST_DONE;
		r_dout     = '0;
		r_wv       = 1'b0;
		r_wid      = '0;
		r_wdata    = '0;
		r_last     = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (func_q != FN_SEND && func_q != FN_RECV && func_q != FN_CLOSE) begin
					state_nxt = S_IDLE;
				end else if (out_free) begin
					load      = 1'b1;
					state_nxt = S_IDLE;
					case (func_q)
						FN_SEND: begin
							if (closed_q) begin
								r_status = ST_CLOSED;
							end else if (!rcv_stat.empty) begin
								rcv_ctrl.pop = 1'b1;
								r_wv         = 1'b1;
								r_wid        = rcv_head;
								r_wdata      = din_q;
							end else if (buf_has_room) begin
								buf_we  = 1'b1;
								buf_inc = 1'b1;
							end else if (!snd_stat.full) begin
								snd_ctrl.push = 1'b1;
								r_status      = ST_BLOCKED;
							end else begin
								r_status = ST_FULL;
							end
						end
						FN_RECV: begin
							if (buf_cnt_q != '0) begin
								buf_pop = 1'b1;
								r_dout  = buf_rd_q;
								if (!snd_stat.empty) begin
									// refill from the oldest sender into the freed slot
									snd_ctrl.pop = 1'b1;
									buf_we       = 1'b1;
									buf_wdata    = snd_head_val;
									r_wv         = 1'b1;
									r_wid        = snd_head_id;
								end else begin
									buf_dec = 1'b1;
								end
							end else if (cap_eff == '0 && !snd_stat.empty) begin
								snd_ctrl.pop = 1'b1;
								r_dout       = snd_head_val;
								r_wv         = 1'b1;
								r_wid        = snd_head_id;
							end else if (closed_q) begin
								r_status = ST_CLOSED;
							end else if (!rcv_stat.full) begin
								rcv_ctrl.push = 1'b1;
								r_status      = ST_BLOCKED;
							end else begin
								r_status = ST_FULL;
							end
						end
						default: begin
							// close: single result unless there are waiters to wake
							if (!closed_q) begin
								closed_set = 1'b1;
								if (!rcv_stat.empty || !snd_stat.empty) begin
									load      = 1'b0;
									state_nxt = S_CLOSE;
								end
							end
						end
					endcase
				end
			end
			S_CLOSE: begin
				if (out_free) begin
					load = 1'b1;
					r_wv = 1'b1;
					if (!rcv_stat.empty) begin
						rcv_ctrl.pop = 1'b1;
						r_wid        = rcv_head;
						r_last       = rcv_stat.single && snd_stat.empty;
					end else begin
						snd_ctrl.pop = 1'b1;
						r_wid        = snd_head_id;
						r_last       = snd_stat.single;
					end
					state_nxt = r_last ? S_IDLE : S_GAP;
				end
			end
			S_GAP: begin
				state_nxt = S_CLOSE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// buffer storage and registered head read
	always_ff @(posedge clk) begin
		if (buf_we) begin
			buf_mem[buf_tail] <= buf_wdata;
		end
		buf_rd_q <= buf_mem[buf_head_q];
	end

	// request capture and result payload
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_q <= req.func;
			tid_q  <= req.thread_id;
			din_q  <= req.data_in;
		end
		if (load) begin
			status_q <= r_status;
			dout_q   <= r_dout;
			wv_q     <= r_wv;
			wid_q    <= r_wid;
			wdata_q  <= r_wdata;
			last_q   <= r_last;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= '0;
			closed_q    <= 1'b0;
			buf_head_q  <= '0;
			buf_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (closed_set) begin
				closed_q <= 1'b1;
			end
			if (buf_pop) begin
				buf_head_q <= buf_head_nxt;
			end
			if (buf_inc) begin
				buf_cnt_q <= buf_cnt_q + 1'b1;
			end else if (buf_dec) begin
				buf_cnt_q <= buf_cnt_q - 1'b1;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = status_q;
	assign rsp.data_out   = dout_q;
	assign rsp.wake_valid = wv_q;
	assign rsp.wake_id    = wid_q;
	assign rsp.wake_data  = wdata_q;
	assign rsp.last       = last_q;

	// fill never passes the buffer size
	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		buf_cnt_q <= BCNT_W'(BUF_DEPTH))
		else $error("buffer fill above depth");

	// a closed channel stays closed
	a_closed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |=> closed_q)
		else $error("closed flag dropped");

	// wake walk only runs while some waiter is left
	a_close_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GAP || state_q == S_CLOSE) |-> (!rcv_stat.empty || !snd_stat.empty))
		else $error("close walk with no waiter");

	// the walk only follows a close request on a channel now closed
	a_close_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLOSE) |-> (closed_q && func_q == FN_CLOSE))
		else $error("close walk without close");

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the blocking message channel. A queued driver sends
// send, receive and close beats with random gaps, a monitor stalls the result
// channel at random and compares every result beat with the channel model's
// prediction. Phases step the capacity through its range, and the run ends
// with full waiter queues woken by a close.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bmc_pkg::*;

	localparam int BUF_DEPTH     = BUF_DEPTH_DEF;
	localparam int WAIT_DEPTH    = WAIT_DEPTH_DEF;
	localparam int VALUE_W       = VALUE_W_DEF;
	localparam int ID_W          = ID_W_DEF;
	localparam int BUF_AW        = $clog2(BUF_DEPTH);
	localparam int WQ_AW         = $clog2(WAIT_DEPTH);
	localparam int CLK_PERIOD    = 20;
	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_CYCLES    = 1000000;
	localparam int NUM_PHASES    = 9;

	// code 3 is not an operation
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [ID_W-1:0]    tid;
		logic [VALUE_W-1:0] data;
	} op_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [VALUE_W-1:0] data_out;
		logic               wake_valid;
		logic [ID_W-1:0]    wake_id;
		logic [VALUE_W-1:0] wake_data;
		logic               last;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;

	bmc_req_if #(.VALUE_W(VALUE_W), .ID_W(ID_W)) req_ch ();
	bmc_rsp_if #(.VALUE_W(VALUE_W), .ID_W(ID_W)) rsp_ch ();

	blocking_message_channel #(
		.BUF_DEPTH(BUF_DEPTH),
		.WAIT_DEPTH(WAIT_DEPTH),
		.VALUE_W(VALUE_W),
		.ID_W(ID_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// driven request beat and result-side ready
	logic drv_valid = 1'b0;
	op_t  cur_op = '0;
	logic rsp_ready = 1'b0;

	assign req_ch.valid     = drv_valid;
	assign req_ch.func      = cur_op.func;
	assign req_ch.thread_id = cur_op.tid;
	assign req_ch.data_in   = cur_op.data;
	assign rsp_ch.ready     = rsp_ready;

	op_t   op_queue[$];
	beat_t owed_results[$];
	bit    idle_on = 1'b0;
	int    err_count = 0;
	int    ops_taken = 0;
	int    beats_seen = 0;
	int    cycle_count = 0;

	// channel model state
	logic [CAP_W-1:0]   m_cap = '0;
	logic               m_closed = 1'b0;
	logic [VALUE_W-1:0] m_buf [BUF_DEPTH];
	logic [BUF_AW-1:0]  m_buf_head = '0;
	logic [BUF_AW:0]    m_buf_cnt = '0;
	logic [ID_W-1:0]    m_tx_id [WAIT_DEPTH];
	logic [VALUE_W-1:0] m_tx_val [WAIT_DEPTH];
	logic [WQ_AW-1:0]   m_tx_head = '0;
	logic [WQ_AW:0]     m_tx_cnt = '0;
	logic [ID_W-1:0]    m_rx_id [WAIT_DEPTH];
	logic [WQ_AW-1:0]   m_rx_head = '0;
	logic [WQ_AW:0]     m_rx_cnt = '0;

	function automatic beat_t make_beat(logic [STAT_W-1:0] st, logic [VALUE_W-1:0] dout,
		logic wv, logic [ID_W-1:0] wid, logic [VALUE_W-1:0] wdata, logic lst);
		beat_t b;
		b.status     = st;
		b.data_out   = dout;
		b.wake_valid = wv;
		b.wake_id    = wid;
		b.wake_data  = wdata;
		b.last       = lst;
		return b;
	endfunction

	// append one expected beat
	task automatic owe_beat(input beat_t b);
		owed_results = {owed_results, b};
	endtask

	task automatic push_buffer(input logic [VALUE_W-1:0] v);
		logic [BUF_AW-1:0] idx;
		if (m_buf_cnt < BUF_DEPTH) begin
			idx = BUF_AW'(m_buf_head + m_buf_cnt);
			m_buf[idx] = v;
			m_buf_cnt = m_buf_cnt + 1'b1;
		end
	endtask

	task automatic pop_sender(output logic [ID_W-1:0] id, output logic [VALUE_W-1:0] v);
		id = m_tx_id[m_tx_head];
		v = m_tx_val[m_tx_head];
		m_tx_head = m_tx_head + 1'b1;
		m_tx_cnt = m_tx_cnt - 1'b1;
	endtask

	task automatic pop_receiver(output logic [ID_W-1:0] id);
		id = m_rx_id[m_rx_head];
		m_rx_head = m_rx_head + 1'b1;
		m_rx_cnt = m_rx_cnt - 1'b1;
	endtask

	// apply one accepted operation to the model and queue the beats it owes
	task automatic model_channel_op(input op_t op);
		int eff;
		int total;
		int k;
		logic [ID_W-1:0] wid;
		logic [VALUE_W-1:0] wval;
		logic [VALUE_W-1:0] got;
		logic [WQ_AW-1:0] idx;
		eff = (m_cap > BUF_DEPTH) ? BUF_DEPTH : int'(m_cap);
		total = 0;
		case (op.func)
			FN_SEND: begin
				if (m_closed) begin
					owe_beat(make_beat(ST_CLOSED, '0, 1'b0, '0, '0, 1'b1));
				end else if (m_rx_cnt > 0) begin
					pop_receiver(wid);
					owe_beat(make_beat(ST_DONE, '0, 1'b1, wid, op.data, 1'b1));
				end else if (eff > 0 && m_buf_cnt < eff) begin
					push_buffer(op.data);
					owe_beat(make_beat(ST_DONE, '0, 1'b0, '0, '0, 1'b1));
				end else if (m_tx_cnt < WAIT_DEPTH) begin
					idx = WQ_AW'(m_tx_head + m_tx_cnt);
					m_tx_id[idx] = op.tid;
					m_tx_val[idx] = op.data;
					m_tx_cnt = m_tx_cnt + 1'b1;
					owe_beat(make_beat(ST_BLOCKED, '0, 1'b0, '0, '0, 1'b1));
				end else begin
					owe_beat(make_beat(ST_FULL, '0, 1'b0, '0, '0, 1'b1));
				end
			end
			FN_RECV: begin
				if (m_buf_cnt > 0) begin
					got = m_buf[m_buf_head];
					m_buf_head = m_buf_head + 1'b1;
					m_buf_cnt = m_buf_cnt - 1'b1;
					if (m_tx_cnt > 0) begin
						// refill from the oldest blocked sender
						pop_sender(wid, wval);
						push_buffer(wval);
						owe_beat(make_beat(ST_DONE, got, 1'b1, wid, '0, 1'b1));
					end else begin
						owe_beat(make_beat(ST_DONE, got, 1'b0, '0, '0, 1'b1));
					end
				end else if (eff == 0 && m_tx_cnt > 0) begin
					pop_sender(wid, wval);
					owe_beat(make_beat(ST_DONE, wval, 1'b1, wid, '0, 1'b1));
				end else if (m_closed) begin
					owe_beat(make_beat(ST_CLOSED, '0, 1'b0, '0, '0, 1'b1));
				end else if (m_rx_cnt < WAIT_DEPTH) begin
					idx = WQ_AW'(m_rx_head + m_rx_cnt);
					m_rx_id[idx] = op.tid;
					m_rx_cnt = m_rx_cnt + 1'b1;
					owe_beat(make_beat(ST_BLOCKED, '0, 1'b0, '0, '0, 1'b1));
				end else begin
					owe_beat(make_beat(ST_FULL, '0, 1'b0, '0, '0, 1'b1));
				end
			end
			FN_CLOSE: begin
				// receivers are woken first, then senders
				if (!m_closed) begin
					m_closed = 1'b1;
					total = int'(m_rx_cnt) + int'(m_tx_cnt);
					for (k = 0; k < total; k++) begin
						if (m_rx_cnt > 0)
							pop_receiver(wid);
						else
							pop_sender(wid, wval);
						owe_beat(make_beat(ST_DONE, '0, 1'b1, wid, '0, k == total - 1));
					end
				end
				if (total == 0)
					owe_beat(make_beat(ST_DONE, '0, 1'b0, '0, '0, 1'b1));
			end
			default: begin
			end
		endcase
	endtask

	// request driver: holds a beat until taken, random idle bursts
	int drv_gap = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_gap <= 0;
		end else begin
			if (drv_valid && req_ch.ready) begin
				model_channel_op(cur_op);
				ops_taken++;
			end
			if (!drv_valid || req_ch.ready) begin
				if (drv_gap > 0) begin
					drv_valid <= 1'b0;
					drv_gap <= drv_gap - 1;
				end else if (idle_on && $urandom_range(0, 7) == 0) begin
					drv_valid <= 1'b0;
					drv_gap <= int'($urandom_range(1, 19)) - 1;
				end else if (op_queue.size() > 0) begin
					cur_op <= op_queue[0];
					op_queue.delete(0);
					drv_valid <= 1'b1;
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
		input logic [VALUE_W-1:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			err_count++;
		end
	endtask

	// result monitor: random stall bursts, compares each beat in order
	int    mon_gap = 0;
	beat_t mon_want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			mon_gap <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ready) begin
				beats_seen++;
				if (owed_results.size() == 0) begin
					$error("result beat with nothing owed: status %0d", rsp_ch.status);
					err_count++;
				end else begin
					mon_want = owed_results[0];
					owed_results.delete(0);
					check_field("status", VALUE_W'(mon_want.status), VALUE_W'(rsp_ch.status));
					check_field("data_out", mon_want.data_out, rsp_ch.data_out);
					check_field("wake_valid", VALUE_W'(mon_want.wake_valid),
						VALUE_W'(rsp_ch.wake_valid));
					check_field("wake_id", VALUE_W'(mon_want.wake_id), VALUE_W'(rsp_ch.wake_id));
					check_field("wake_data", mon_want.wake_data, rsp_ch.wake_data);
					check_field("last", VALUE_W'(mon_want.last), VALUE_W'(rsp_ch.last));
				end
			end
			if (mon_gap > 0) begin
				rsp_ready <= 1'b0;
				mon_gap <= mon_gap - 1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				rsp_ready <= 1'b0;
				mon_gap <= int'($urandom_range(1, 19)) - 1;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= MAX_CYCLES) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	task automatic queue_op(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] t,
		input logic [VALUE_W-1:0] d);
		op_t o;
		o.func = f;
		o.tid = t;
		o.data = d;
		op_queue = {op_queue, o};
	endtask

	// wait until every queued beat is taken and answered, then let the block settle
	task automatic wait_quiet();
		@(negedge clk);
		while (op_queue.size() != 0 || drv_valid || owed_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_cap = v;
	endtask

	initial begin : stimulus
		int phase_cap [NUM_PHASES];
		int phase_len [NUM_PHASES];
		int p;
		int n;
		int bias;
		int r;
		logic [VALUE_W-1:0] d;

		phase_cap = '{1, 16, 31, 5, 2, 0, 4, 16, 0};
		phase_len = '{35, 35, 35, 30, 30, 35, 30, 30, 25};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;

		// rendezvous at reset capacity, field extremes, unused code
		queue_op(FN_RECV, '0, '0);
		queue_op(FN_SEND, {ID_W{1'b1}}, {VALUE_W{1'b1}});
		queue_op(FN_SEND, '0, '0);
		queue_op(FN_RECV, {ID_W{1'b1}}, {VALUE_W{1'b1}});
		queue_op(FN_UNUSED, 8'hA5, 32'h5A5A_A5A5);
		wait_quiet();

		// random send/receive traffic, capacity raised and lowered between phases
		bias = 50;
		for (p = 0; p < NUM_PHASES; p++) begin
			set_capacity(CAP_W'(phase_cap[p]));
			if (p == NUM_PHASES - 1)
				idle_on = 1'b0;
			n = 0;
			while (n < phase_len[p]) begin
				if ($urandom_range(0, 11) == 0)
					bias = $urandom_range(10, 90);
				r = $urandom_range(0, 99);
				if ($urandom_range(0, 15) == 0)
					d = $urandom_range(0, 1) ? {VALUE_W{1'b1}} : '0;
				else
					d = $urandom;
				if (r < 3) begin
					queue_op(FN_UNUSED, ID_W'($urandom_range(0, 255)), d);
				end else begin
					queue_op((r < bias) ? FN_SEND : FN_RECV, ID_W'($urandom_range(0, 255)), d);
					n++;
				end
			end
			wait_quiet();
		end

		// empty the channel: wake receivers, then drain buffer and senders
		repeat (int'(m_rx_cnt)) queue_op(FN_SEND, ID_W'($urandom_range(0, 255)), $urandom);
		wait_quiet();
		set_capacity('0);
		repeat (int'(m_buf_cnt) + int'(m_tx_cnt))
			queue_op(FN_RECV, ID_W'($urandom_range(0, 255)), '0);
		wait_quiet();

		// fill both waiter queues past the top, then close twice and use it closed
		repeat (WAIT_DEPTH + 1) queue_op(FN_SEND, ID_W'($urandom_range(0, 255)), $urandom);
		wait_quiet();
		set_capacity(CAP_W'(BUF_DEPTH));
		repeat (WAIT_DEPTH + 1) queue_op(FN_RECV, ID_W'($urandom_range(0, 255)), $urandom);
		queue_op(FN_CLOSE, ID_W'($urandom_range(0, 255)), $urandom);
		queue_op(FN_CLOSE, ID_W'($urandom_range(0, 255)), $urandom);
		queue_op(FN_SEND, ID_W'($urandom_range(0, 255)), $urandom);
		queue_op(FN_RECV, ID_W'($urandom_range(0, 255)), $urandom);
		wait_quiet();

		$display("run covered %0d operations and %0d result beats, capacity 0 to 31,",
			ops_taken, beats_seen);
		$display("full waiter queues and a close waking every waiter");
		if (err_count == 0 && owed_results.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
